// File: design/tdc_pkg.sv
`default_nettype none

package tdc_pkg;

  // Window sums and levels are 13 bits and saturate at full scale
  localparam int unsigned ACC_W = 13;
  localparam logic [ACC_W-1:0] ACC_MAX = 13'h1FFF;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;

  // Threshold reset values
  localparam logic [ACC_W-1:0] LOWER_RESET = 13'd57;
  localparam logic [ACC_W-1:0] UPPER_RESET = 13'd123;

  // Crossing event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_IN   = 2'd1;
  localparam logic [1:0] EV_OUT  = 2'd2;

  // Updated judgement and level of one beam
  typedef struct packed {
    logic             blocked;
    logic [ACC_W-1:0] level;
  } beam_status_t;

endpackage

`default_nettype wire

// File: design/two_beam_direction_counter_top.sv
`default_nettype none

// Two-beam infrared direction counter. Each request is one LED modulation
// tick carrying the LED state and one ADC code per receiver; every request
// yields exactly one result with the crossing event, both beam judgements and
// both levels. One request is taken per clock cycle; each accepted request
// passes the input register, then one compute stage that updates the beam
// state and loads the result register. Throughput drops only while the
// result register is held by out_ready low. Threshold writes on the cfg
// port are always taken and should happen while idle.
module two_beam_direction_counter_top
  import tdc_pkg::*;
#(
  parameter int unsigned SUPERSAMPLE = 2,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   in_led_on,
  input  wire logic [SAMPLE_BITS-1:0] in_inside_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_outside_sample,

  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [1:0]             out_crossing_event,
  output      logic                   out_inside_blocked,
  output      logic                   out_outside_blocked,
  output      logic [ACC_W-1:0]       out_inside_level,
  output      logic [ACC_W-1:0]       out_outside_level,

  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ACC_W-1:0]       cfg_data
);

  localparam int unsigned PERIOD = 2 * SUPERSAMPLE;
  localparam int unsigned PH_W   = (PERIOD > 2) ? $clog2(PERIOD) : 1;

  // Direction machine codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_IN_FIRST  = 3'd1;
  localparam logic [2:0] ST_IN_BOTH   = 3'd2;
  localparam logic [2:0] ST_IN_LAST   = 3'd3;
  localparam logic [2:0] ST_OUT_FIRST = 3'd4;
  localparam logic [2:0] ST_OUT_BOTH  = 3'd5;
  localparam logic [2:0] ST_OUT_LAST  = 3'd6;

  logic [ACC_W-1:0]       lower_r;
  logic [ACC_W-1:0]       upper_r;

  logic                   s1_valid_r;
  logic                   s1_lit_r;
  logic [SAMPLE_BITS-1:0] s1_ins_r;
  logic [SAMPLE_BITS-1:0] s1_outs_r;

  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic [2:0]             dir_r, dir_nxt;
  logic [1:0]             event_nxt;
  logic                   window_end;

  logic                   out_valid_r;
  logic [1:0]             event_r;
  beam_status_t           ins_stat_r, outs_stat_r;
  beam_status_t           ins_stat, outs_stat;

  logic                   advance;
  logic                   compute;
  logic                   ib, ob;

  // Hold the threshold registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOWER: lower_r <= cfg_data;
        REG_UPPER: upper_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the compute stage moves when the result register frees up
  assign advance  = !out_valid_r || out_ready;
  assign compute  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_lit_r  <= in_led_on;
      s1_ins_r  <= in_inside_sample;
      s1_outs_r <= in_outside_sample;
    end
  end

  // Advance the window position; a window closes at wrap and one tick before
  assign phase_nxt  = (phase_r == PH_W'(PERIOD - 1)) ? '0 : phase_r + PH_W'(1);
  assign window_end = (phase_nxt == '0) || (phase_nxt == PH_W'(PERIOD - 1));

  tdc_beam #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_beam_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (compute),
    .lit        (s1_lit_r),
    .code       (s1_ins_r),
    .window_end (window_end),
    .lower_thr  (lower_r),
    .upper_thr  (upper_r),
    .status     (ins_stat)
  );

  tdc_beam #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_beam_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (compute),
    .lit        (s1_lit_r),
    .code       (s1_outs_r),
    .window_end (window_end),
    .lower_thr  (lower_r),
    .upper_thr  (upper_r),
    .status     (outs_stat)
  );

  assign ib = ins_stat.blocked;
  assign ob = outs_stat.blocked;

  // Track the order in which the beams block and clear
  always_comb begin
    dir_nxt   = dir_r;
    event_nxt = EV_NONE;
    unique case (dir_r)
      ST_IN_FIRST: begin
        if (ob) dir_nxt = ST_IN_BOTH;
        else if (!ib) dir_nxt = ST_IDLE;
      end
      ST_IN_BOTH: begin
        if (!ib) dir_nxt = ST_IN_LAST;
        else if (!ob) dir_nxt = ST_IN_FIRST;
      end
      ST_IN_LAST: begin
        if (ib) begin
          dir_nxt = ST_IN_BOTH;
        end else if (!ob) begin
          dir_nxt   = ST_IDLE;
          event_nxt = EV_IN;
        end
      end
      ST_OUT_FIRST: begin
        if (ib) dir_nxt = ST_OUT_BOTH;
        else if (!ob) dir_nxt = ST_IDLE;
      end
      ST_OUT_BOTH: begin
        if (!ob) dir_nxt = ST_OUT_LAST;
        else if (!ib) dir_nxt = ST_OUT_FIRST;
      end
      ST_OUT_LAST: begin
        if (ob) begin
          dir_nxt = ST_OUT_BOTH;
        end else if (!ib) begin
          dir_nxt   = ST_IDLE;
          event_nxt = EV_OUT;
        end
      end
      default: begin
        if (ob) dir_nxt = ST_OUT_FIRST;
        else if (ib) dir_nxt = ST_IN_FIRST;
        else dir_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      dir_r   <= ST_IDLE;
    end else if (compute) begin
      phase_r <= phase_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      event_r     <= event_nxt;
      ins_stat_r  <= ins_stat;
      outs_stat_r <= outs_stat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_crossing_event  = event_r;
  assign out_inside_blocked  = ins_stat_r.blocked;
  assign out_outside_blocked = outs_stat_r.blocked;
  assign out_inside_level    = ins_stat_r.level;
  assign out_outside_level   = outs_stat_r.level;

  // A crossing completes only with both beams clear
  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (event_r != EV_NONE) |-> !ins_stat_r.blocked && !outs_stat_r.blocked)
    else $error("crossing reported while a beam is blocked");

  // A reported crossing leaves the direction machine idle
  a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (event_r != EV_NONE) |-> dir_r == ST_IDLE)
    else $error("direction machine not idle after a crossing");

  // A held result freezes the window and direction state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(phase_r) && $stable(dir_r))
    else $error("state advanced while the result was held");

endmodule

`default_nettype wire

// File: design/tdc_beam.sv
`default_nettype none

module tdc_beam
  import tdc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   lit,
  input  wire logic [SAMPLE_BITS-1:0] code,
  input  wire logic                   window_end,
  input  wire logic [ACC_W-1:0]       lower_thr,
  input  wire logic [ACC_W-1:0]       upper_thr,
  output beam_status_t                status
);

  localparam int unsigned SUM_W = ((SAMPLE_BITS > ACC_W) ? SAMPLE_BITS : ACC_W) + 1;

  logic [ACC_W-1:0] on_acc_r, on_acc_nxt;
  logic [ACC_W-1:0] off_acc_r, off_acc_nxt;
  logic [ACC_W-1:0] on_lat_r, on_lat_nxt;
  logic [ACC_W-1:0] off_lat_r, off_lat_nxt;
  logic             on_seen_r, on_seen_nxt;
  logic             off_seen_r, off_seen_nxt;
  logic             blocked_r, blocked_nxt;

  logic [ACC_W-1:0] acc_sel;
  logic [SUM_W-1:0] sum;
  logic [ACC_W-1:0] sum_sat;
  logic [ACC_W-1:0] diff;
  logic [ACC_W-1:0] level;
  logic             both_seen;

  // Saturating add into the accumulator picked by the LED phase
  assign acc_sel = lit ? on_acc_r : off_acc_r;
  assign sum     = SUM_W'(acc_sel) + SUM_W'(code);
  assign sum_sat = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];

  // Accumulate, then latch and clear at the window end
  always_comb begin
    on_acc_nxt   = on_acc_r;
    off_acc_nxt  = off_acc_r;
    on_lat_nxt   = on_lat_r;
    off_lat_nxt  = off_lat_r;
    on_seen_nxt  = on_seen_r;
    off_seen_nxt = off_seen_r;
    if (lit) begin
      on_acc_nxt = sum_sat;
      if (window_end) begin
        on_lat_nxt  = sum_sat;
        on_acc_nxt  = '0;
        on_seen_nxt = 1'b1;
      end
    end else begin
      off_acc_nxt = sum_sat;
      if (window_end) begin
        off_lat_nxt  = sum_sat;
        off_acc_nxt  = '0;
        off_seen_nxt = 1'b1;
      end
    end
  end

  // Lit minus dark, clamped at zero; zero until both sums are latched
  assign both_seen = on_seen_nxt && off_seen_nxt;
  assign diff      = (on_lat_nxt > off_lat_nxt) ? (on_lat_nxt - off_lat_nxt) : '0;
  assign level     = both_seen ? diff : '0;

  // Judge with hysteresis between the two thresholds
  always_comb begin
    blocked_nxt = blocked_r;
    if (window_end && both_seen) begin
      if (level < lower_thr) begin
        blocked_nxt = 1'b1;
      end else if (level > upper_thr) begin
        blocked_nxt = 1'b0;
      end
    end
  end

  assign status.blocked = blocked_nxt;
  assign status.level   = level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_acc_r   <= '0;
      off_acc_r  <= '0;
      on_lat_r   <= '0;
      off_lat_r  <= '0;
      on_seen_r  <= 1'b0;
      off_seen_r <= 1'b0;
      blocked_r  <= 1'b0;
    end else if (step) begin
      on_acc_r   <= on_acc_nxt;
      off_acc_r  <= off_acc_nxt;
      on_lat_r   <= on_lat_nxt;
      off_lat_r  <= off_lat_nxt;
      on_seen_r  <= on_seen_nxt;
      off_seen_r <= off_seen_nxt;
      blocked_r  <= blocked_nxt;
    end
  end

endmodule

`default_nettype wire
